@@ sv/nfha_pkg.sv @@
// Shared constants for the next-fit heap allocator: status codes, actions, register indexes.
`default_nettype none
package nfha_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;
    localparam logic [1:0] CFG_LINE_LOG2  = 2'd2;

    localparam logic [31:0] HEAP_BYTES_RST = 32'd1048576;
    localparam logic [3:0]  LINE_LOG2_RST  = 4'd2;

endpackage
`default_nettype wire

@@ sv/nfha_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module nfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ sv/next_fit_heap_allocator.sv @@
// Next-fit heap allocator: segment ring in RAM, walked one entry per cycle.
//
// Input stream (s_axis): one word per request; tuser selects allocate (0) or free (1).
// Output stream (m_axis): one word per request with status, block address and size.
// Registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while idle; the block does not enforce it. A write of the
// heap base or size rebuilds the table as one free segment.
//
// An allocate walks the segment ring from the rover, one RAM read per cycle; a free
// walks the ring from the heap's first segment looking for the address. Up to
// MAX_SEGMENTS entries are visited. A split, clear or merge then updates the links,
// each link update being a read-modify-write of the segment RAM.
// After reset (and after a heap base/size write) the init state writes entry zero;
// s_axis_tready is low while it does.
// A new request is taken while the last result still waits on m_axis; if the
// receiver stalls, the next result is held until the output register frees.
`default_nettype none
module next_fit_heap_allocator
    import nfha_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // req_size[31:0], free_addr[63:32]
    input  wire logic        s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,   // status[2:0], block_addr[34:3], block_size[66:35]
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [32:0] RND_LIM = (ADDR_BITS >= 32) ? {1'b0, 32'hFFFF_FFFF}
                                    : 33'((64'd1 << ADDR_BITS) - 64'd1);

    typedef struct packed {
        logic [AW-1:0] start;
        logic [31:0]   len;
        logic          used;
        logic [IW-1:0] prev;
        logic [IW-1:0] next;
    } t_seg;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_AREQ, S_ACHK, S_SPLIT, S_FREQ, S_FCHK, S_LWAIT,
        S_RWAIT, S_MRD, S_MWR, S_PUSH1, S_PUSH2, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_SPLIT_PREV, OP_SPLIT_CUR, OP_BOTH_LFT, OP_BOTH_R2, OP_LEFT_LFT,
        OP_LEFT_RGT, OP_RIGHT_LFT, OP_RIGHT_RGT, OP_CLEAR
    } t_op;

    function automatic logic [AW-1:0] f_to_aw(input logic [31:0] v);
        logic [AW+31:0] t;
        t = {{AW{1'b0}}, v};
        return t[AW-1:0];
    endfunction

    function automatic logic [31:0] f_to_32(input logic [AW-1:0] v);
        logic [AW+31:0] t;
        t = {32'd0, v};
        return t[31:0];
    endfunction

    t_state        r_state;
    t_op           r_op;
    logic [31:0]   r_base, r_bytes;
    logic [3:0]    r_lsl;
    logic [IW-1:0] r_rover, r_head, r_cur, r_new, r_maddr, r_r2;
    logic [CW-1:0] r_fill, r_sp;
    logic [31:0]   r_rounded, r_sum, r_llen;
    logic          r_lused, r_push2;
    logic [AW-1:0] r_faddr;
    t_seg          r_seg;
    logic [2:0]    r_rstat;
    logic [31:0]   r_raddr, r_rsize;
    logic          r_ovalid;
    logic [71:0]   r_otdata;

    t_seg          w_rd, w_wdata, w_mod;
    logic          w_we, w_swe;
    logic [IW-1:0] w_raddr, w_waddr, w_sdata, w_stk_rd;
    logic [CW-1:0] w_sp_dec;
    logic [32:0]   w_gmask, w_rsum, w_round;
    logic          w_fit, w_exact, w_found, w_lfree, w_rfree, w_have_free;

    assign w_gmask = (33'd1 << r_lsl) - 33'd1;
    assign w_rsum  = {1'b0, s_axis_tdata[31:0]} + w_gmask;
    assign w_round = w_rsum & ~w_gmask;
    assign w_sp_dec = r_sp - CW'(1);
    assign w_fit   = !w_rd.used && (w_rd.len >= r_rounded);
    assign w_exact = (w_rd.len == r_rounded);
    assign w_found = w_rd.used && (w_rd.start == r_faddr);
    assign w_lfree = (r_cur != r_head) && !r_lused;
    assign w_rfree = (r_seg.next != r_head) && !w_rd.used;
    assign w_have_free = (r_sp != '0) || (r_fill != CW'(MAX_SEGMENTS));

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_otdata;

    nfha_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    nfha_ram #(.WIDTH(IW), .DEPTH(MAX_SEGMENTS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (r_sp[IW-1:0]),
        .i_wdata (w_sdata),
        .i_raddr (w_sp_dec[IW-1:0]),
        .o_rdata (w_stk_rd)
    );

    // modify the entry just read for the pending link update
    always_comb begin
        w_mod = w_rd;
        case (r_op)
            OP_SPLIT_PREV: w_mod.next = r_new;
            OP_SPLIT_CUR: begin
                w_mod.prev  = r_new;
                w_mod.start = w_rd.start + f_to_aw(r_rounded);
                w_mod.len   = w_rd.len - r_rounded;
            end
            OP_BOTH_LFT: begin
                w_mod.len  = r_sum;
                w_mod.next = r_r2;
            end
            OP_BOTH_R2:  w_mod.prev = r_seg.prev;
            OP_LEFT_LFT: begin
                w_mod.len  = r_sum;
                w_mod.next = r_seg.next;
            end
            OP_LEFT_RGT:  w_mod.prev = r_seg.prev;
            OP_RIGHT_LFT: w_mod.next = r_seg.next;
            OP_RIGHT_RGT: begin
                w_mod.start = r_seg.start;
                w_mod.len   = r_sum;
                w_mod.prev  = r_seg.prev;
            end
            OP_CLEAR: w_mod.used = 1'b0;
            default: w_mod = w_rd;
        endcase
    end

    always_comb begin
        w_raddr = r_cur;
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = w_rd;
        w_swe   = 1'b0;
        w_sdata = r_cur;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{start: f_to_aw(r_base), len: r_bytes, used: 1'b0,
                            prev: '0, next: '0};
            end
            S_ACHK: begin
                w_raddr = w_rd.next;
                if (w_fit && w_exact) begin
                    w_we         = 1'b1;
                    w_wdata      = w_rd;
                    w_wdata.used = 1'b1;
                end
            end
            S_FCHK:  w_raddr = w_found ? w_rd.prev : w_rd.next;
            S_LWAIT: w_raddr = r_seg.next;
            S_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = r_new;
                w_wdata = '{start: r_seg.start, len: r_rounded, used: 1'b1,
                            prev: r_seg.prev, next: r_cur};
            end
            S_MRD: w_raddr = r_maddr;
            S_MWR: begin
                w_we    = 1'b1;
                w_waddr = r_maddr;
                w_wdata = w_mod;
            end
            S_PUSH1: w_swe = 1'b1;
            S_PUSH2: begin
                w_swe   = 1'b1;
                w_sdata = r_seg.next;
            end
            default: w_raddr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_op     <= OP_CLEAR;
            r_base   <= '0;
            r_bytes  <= HEAP_BYTES_RST;
            r_lsl    <= LINE_LOG2_RST;
            r_rover  <= '0;
            r_head   <= '0;
            r_fill   <= CW'(1);
            r_sp     <= '0;
            r_push2  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_rstat <= ST_OK;
                        r_raddr <= '0;
                        r_rsize <= '0;
                        r_push2 <= 1'b0;
                        if (s_axis_tuser == ACT_FREE) begin
                            r_faddr <= f_to_aw(s_axis_tdata[63:32]);
                            r_cur   <= r_head;
                            r_state <= S_FREQ;
                        end else if (s_axis_tdata[31:0] == '0) begin
                            r_rstat <= ST_ZERO;
                            r_state <= S_DONE;
                        end else if (w_round > RND_LIM) begin
                            r_rstat <= ST_NO_SPACE;
                            r_state <= S_DONE;
                        end else begin
                            r_rounded <= w_round[31:0];
                            r_cur     <= r_rover;
                            r_state   <= S_AREQ;
                        end
                    end
                end
                S_AREQ: r_state <= S_ACHK;
                S_ACHK: begin
                    r_seg <= w_rd;
                    if (w_fit && w_exact) begin
                        r_rover <= w_rd.next;
                        r_raddr <= f_to_32(w_rd.start);
                        r_rsize <= r_rounded;
                        r_state <= S_DONE;
                    end else if (w_fit) begin
                        if (r_sp != '0) begin
                            r_new   <= w_stk_rd;
                            r_sp    <= w_sp_dec;
                            r_state <= S_SPLIT;
                        end else if (w_have_free) begin
                            r_new   <= r_fill[IW-1:0];
                            r_fill  <= r_fill + CW'(1);
                            r_state <= S_SPLIT;
                        end else begin
                            r_rstat <= ST_FULL;
                            r_state <= S_DONE;
                        end
                    end else if (w_rd.next == r_rover) begin
                        r_rstat <= ST_NO_SPACE;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= w_rd.next;
                    end
                end
                S_SPLIT: begin
                    if (r_head == r_cur) begin
                        r_head <= r_new;
                    end
                    r_rover <= r_cur;
                    r_raddr <= f_to_32(r_seg.start);
                    r_rsize <= r_rounded;
                    r_op    <= OP_SPLIT_PREV;
                    r_maddr <= r_seg.prev;
                    r_state <= S_MRD;
                end
                S_FREQ: r_state <= S_FCHK;
                S_FCHK: begin
                    r_seg <= w_rd;
                    if (w_found) begin
                        r_state <= S_LWAIT;
                    end else if (w_rd.next == r_head) begin
                        r_rstat <= ST_UNKNOWN;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= w_rd.next;
                    end
                end
                S_LWAIT: begin
                    r_lused <= w_rd.used;
                    r_llen  <= w_rd.len;
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_raddr <= f_to_32(r_seg.start);
                    r_rsize <= r_seg.len;
                    r_r2    <= w_rd.next;
                    r_maddr <= r_seg.prev;
                    r_state <= S_MRD;
                    if (w_lfree && w_rfree) begin
                        r_sum   <= r_llen + r_seg.len + w_rd.len;
                        r_op    <= OP_BOTH_LFT;
                        r_push2 <= 1'b1;
                        if (r_rover == r_cur || r_rover == r_seg.next) begin
                            r_rover <= w_rd.next;
                        end
                    end else if (w_lfree) begin
                        r_sum <= r_llen + r_seg.len;
                        r_op  <= OP_LEFT_LFT;
                        if (r_rover == r_cur) begin
                            r_rover <= r_seg.next;
                        end
                    end else if (w_rfree) begin
                        r_sum <= w_rd.len + r_seg.len;
                        r_op  <= OP_RIGHT_LFT;
                        if (r_rover == r_cur) begin
                            r_rover <= r_seg.next;
                        end
                        if (r_head == r_cur) begin
                            r_head <= r_seg.next;
                        end
                    end else begin
                        r_op    <= OP_CLEAR;
                        r_maddr <= r_cur;
                    end
                end
                S_MRD: r_state <= S_MWR;
                S_MWR: begin
                    r_state <= S_MRD;
                    case (r_op)
                        OP_SPLIT_PREV: begin
                            r_op    <= OP_SPLIT_CUR;
                            r_maddr <= r_cur;
                        end
                        OP_BOTH_LFT: begin
                            r_op    <= OP_BOTH_R2;
                            r_maddr <= r_r2;
                        end
                        OP_LEFT_LFT: begin
                            r_op    <= OP_LEFT_RGT;
                            r_maddr <= r_seg.next;
                        end
                        OP_RIGHT_LFT: begin
                            r_op    <= OP_RIGHT_RGT;
                            r_maddr <= r_seg.next;
                        end
                        OP_BOTH_R2, OP_LEFT_RGT, OP_RIGHT_RGT: r_state <= S_PUSH1;
                        default: r_state <= S_DONE;
                    endcase
                end
                // return the dropped entries to the free stack
                S_PUSH1: begin
                    r_sp    <= r_sp + CW'(1);
                    r_state <= r_push2 ? S_PUSH2 : S_DONE;
                end
                S_PUSH2: begin
                    r_sp    <= r_sp + CW'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_otdata <= {5'd0, r_rsize, r_raddr, r_rstat};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE, CFG_HEAP_BYTES: begin
                        if (i_cfg_index == CFG_HEAP_BASE) begin
                            r_base <= i_cfg_data;
                        end else begin
                            r_bytes <= i_cfg_data;
                        end
                        r_rover <= '0;
                        r_head  <= '0;
                        r_fill  <= CW'(1);
                        r_sp    <= '0;
                        r_state <= S_INIT;
                    end
                    CFG_LINE_LOG2: r_lsl <= i_cfg_data[3:0];
                    default: r_lsl <= r_lsl;
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_sp < r_fill)
        else $error("free stack holds more entries than were handed out");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     r_fill <= CW'(MAX_SEGMENTS))
        else $error("fill count beyond table depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside completion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     (r_state == S_MWR && r_op == OP_SPLIT_CUR) |-> r_rover == r_cur)
        else $error("rover not parked on split remainder");
`endif

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the next-fit heap allocator: drives requests, predicts results.
`default_nettype none
module testbench;
    import nfha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        action;
        logic [31:0] req_size;
        logic [31:0] free_addr;
    } request_t;

    // packed from the top bit down: size, address, status in the low bits
    typedef struct packed {
        logic [31:0] block_size;
        logic [31:0] block_addr;
        logic [2:0]  status;
    } reply_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    next_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [31:0] base_q, bytes_q;
    logic [3:0]  gran_log2_q;
    logic [31:0] seg_start [NSEG];
    logic [31:0] seg_len   [NSEG];
    logic        seg_used  [NSEG];
    logic        seg_valid [NSEG];
    int          seg_next  [NSEG];
    int          seg_prev  [NSEG];
    int          rover, head;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    logic [31:0] live_blocks[$];
    int  send_idle_pct, recv_stall_pct;
    bit  failed;
    int  quiet_cycles;

    // set when a word was taken at the last rising edge, seen by the driver
    logic s_axis_tready_q;

    function automatic void table_rebuild();
        for (int i = 0; i < NSEG; i++) begin
            seg_start[i] = '0; seg_len[i] = '0; seg_used[i] = 1'b0;
            seg_valid[i] = 1'b0; seg_next[i] = 0; seg_prev[i] = 0;
        end
        seg_start[0] = base_q;
        seg_len[0] = bytes_q;
        seg_valid[0] = 1'b1;
        rover = 0;
        head = 0;
    endfunction

    function automatic reply_t predict_alloc(logic [31:0] size);
        reply_t r;
        logic [63:0] gran, rounded;
        int cur, e;
        r = '0;
        gran = 64'd1 << gran_log2_q;
        rounded = ({32'd0, size} + gran - 1) & ~(gran - 1);
        cur = rover;
        if (size == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        if (rounded > 64'hFFFF_FFFF) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        for (int steps = 0; steps < NSEG; steps++) begin
            if (!seg_used[cur] && {32'd0, seg_len[cur]} >= rounded) begin
                if ({32'd0, seg_len[cur]} == rounded) begin
                    seg_used[cur] = 1'b1;
                    rover = seg_next[cur];
                    r.block_addr = seg_start[cur];
                    r.block_size = rounded[31:0];
                    return r;
                end
                e = 0;
                while (e < NSEG && seg_valid[e]) e++;
                if (e >= NSEG) begin
                    r.status = ST_FULL;
                    return r;
                end
                seg_valid[e] = 1'b1;
                seg_used[e] = 1'b1;
                seg_start[e] = seg_start[cur];
                seg_len[e] = rounded[31:0];
                seg_prev[e] = seg_prev[cur];
                seg_next[e] = cur;
                seg_next[seg_prev[cur]] = e;
                seg_prev[cur] = e;
                if (head == cur) head = e;
                seg_start[cur] = seg_start[cur] + rounded[31:0];
                seg_len[cur] = seg_len[cur] - rounded[31:0];
                rover = cur;
                r.block_addr = seg_start[e];
                r.block_size = rounded[31:0];
                return r;
            end
            cur = seg_next[cur];
            if (cur == rover) break;
        end
        r.status = ST_NO_SPACE;
        return r;
    endfunction

    function automatic reply_t predict_free(logic [31:0] addr);
        reply_t r;
        int b, lft, rgt, r2;
        bit lfree, rfree;
        r = '0;
        b = NSEG;
        for (int i = 0; i < NSEG; i++)
            if (b == NSEG && seg_valid[i] && seg_used[i] && seg_start[i] == addr) b = i;
        if (b == NSEG) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        r.block_addr = seg_start[b];
        r.block_size = seg_len[b];
        lft = seg_prev[b];
        rgt = seg_next[b];
        r2 = seg_next[rgt];
        lfree = (b != head) && !seg_used[lft];
        rfree = (rgt != head) && !seg_used[rgt];
        if (lfree && rfree) begin
            seg_len[lft] = seg_len[lft] + seg_len[b] + seg_len[rgt];
            seg_next[lft] = r2;
            seg_prev[r2] = lft;
            if (rover == b || rover == rgt) rover = r2;
            seg_valid[b] = 1'b0;
            seg_valid[rgt] = 1'b0;
        end else if (lfree) begin
            seg_len[lft] = seg_len[lft] + seg_len[b];
            seg_next[lft] = rgt;
            seg_prev[rgt] = lft;
            if (rover == b) rover = rgt;
            seg_valid[b] = 1'b0;
        end else if (rfree) begin
            seg_start[rgt] = seg_start[b];
            seg_len[rgt] = seg_len[rgt] + seg_len[b];
            seg_next[lft] = rgt;
            seg_prev[rgt] = lft;
            if (rover == b) rover = rgt;
            if (head == b) head = rgt;
            seg_valid[b] = 1'b0;
        end
        seg_used[b] = 1'b0;
        return r;
    endfunction

    // driver: present the next request and the receiver's ready at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_axis_tready_q) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    request_t q;
                    q = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= q.action;
                    s_axis_tdata  <= {q.free_addr, q.req_size};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

    // monitor: predict on input accept, compare on output accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                reply_t p;
                if (s_axis_tuser == ACT_ALLOC) p = predict_alloc(s_axis_tdata[31:0]);
                else p = predict_free(s_axis_tdata[63:32]);
                expected_replies.push_back(p);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                reply_t got, want;
                got = reply_t'(m_axis_tdata[66:0]);
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    failed = 1'b1;
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, want.status, got.status);
                    if (got.block_addr !== want.block_addr)
                        $display("%0t: block_addr expected %h actual %h",
                                 $realtime, want.block_addr, got.block_addr);
                    if (got.block_size !== want.block_size)
                        $display("%0t: block_size expected %h actual %h",
                                 $realtime, want.block_size, got.block_size);
                    if (got !== want) failed = 1'b1;
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HEAP_BASE: begin base_q = value; table_rebuild(); end
            CFG_HEAP_BYTES: begin bytes_q = value; table_rebuild(); end
            default: gran_log2_q = value[3:0];
        endcase
        live_blocks.delete();
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic void push_alloc(logic [31:0] size);
        request_t q;
        q.action = ACT_ALLOC; q.req_size = size; q.free_addr = $urandom();
        pending_reqs.push_back(q);
    endfunction

    function automatic void push_free(logic [31:0] addr);
        request_t q;
        q.action = ACT_FREE; q.req_size = $urandom(); q.free_addr = addr;
        pending_reqs.push_back(q);
    endfunction

    task automatic drain_harvest();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(posedge i_clk);
        live_blocks.delete();
        for (int i = 0; i < NSEG; i++)
            if (seg_valid[i] && seg_used[i]) live_blocks.push_back(seg_start[i]);
    endtask

    // build a workload; frees name addresses harvested from the predictor's live blocks
    task automatic run_phase(int n, int max_size);
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 50) begin
                push_alloc($urandom_range(max_size, 1));
            end else if (pick < 53) begin
                push_alloc($urandom());
            end else if (pick < 55) begin
                push_alloc(32'd0);
            end else if (pick < 93) begin
                // free an address we believe is live; the predictor decides
                a = (live_blocks.size() > 0) ?
                    live_blocks[$urandom_range(live_blocks.size() - 1)] : $urandom();
                push_free(a);
            end else begin
                push_free($urandom());
            end
            // keep a pool of likely block starts: drain once in a while and harvest
            if (pending_reqs.size() >= 8) begin
                drain_harvest();
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        failed = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        base_q = 32'd0;
        bytes_q = HEAP_BYTES_RST;
        gran_log2_q = LINE_LOG2_RST;
        table_rebuild();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero size, overflow, exact fit, merges, double free
        push_alloc(32'd0);
        push_alloc(32'hFFFF_FFFF);
        push_alloc(32'd1);
        push_alloc(32'd5);
        push_alloc(32'd16);
        push_free(32'd4);
        push_free(32'd4);
        push_free(32'd0);
        push_free(32'd12);
        push_free(32'hFFFF_FFFF);
        push_alloc(32'd1048576);
        push_free(32'd0);
        push_alloc(32'd1048577);
        drain();

        write_reg(CFG_LINE_LOG2, 4'd0);
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
        write_reg(CFG_HEAP_BYTES, 32'd512);
        push_alloc(32'd100);
        push_alloc(32'd412);
        push_alloc(32'd1);
        push_free(32'hFFFF_FF64);
        push_free(32'hFFFF_FF00);
        drain();

        write_reg(CFG_LINE_LOG2, 4'd15);
        write_reg(CFG_HEAP_BYTES, 32'hFFFF_FFFF);
        push_alloc(32'hFFFF_0001);
        push_alloc(32'd1);
        drain();

        // random phases across idle patterns and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            write_reg(CFG_LINE_LOG2, $urandom_range(12));
            write_reg(CFG_HEAP_BASE, (ph == 7) ? 32'hFFFF_FFFF : $urandom());
            write_reg(CFG_HEAP_BYTES, (ph == 0) ? 32'd0 : $urandom_range(65536, 256));
            run_phase(230, (ph < 4) ? 64 : 4096);
        end

        if (!failed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
